// ===== src/lpfr_pkg.sv =====
// Package for the length-prefixed frame receiver: word types, state and
// event codes, request codes and register indexes. No dependencies.
package lpfr_pkg;

    localparam int unsigned HEADER_BYTES = 8;
    localparam int unsigned HCNT_W       = $clog2(HEADER_BYTES);
    localparam int unsigned LEN_W        = 26;
    localparam int unsigned WORD_W       = 32;

    localparam logic [WORD_W-1:0] MAGIC_RESET       = 32'h3130_5456;
    localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RESET = 26'd33554432;

    // request codes
    localparam logic [1:0] REQ_OPEN    = 2'd0;
    localparam logic [1:0] REQ_CONNECT = 2'd1;
    localparam logic [1:0] REQ_BYTE    = 2'd2;
    localparam logic [1:0] REQ_CLOSE   = 2'd3;

    // result event codes
    localparam logic [2:0] EV_CONNECTED      = 3'd0;
    localparam logic [2:0] EV_CONNECT_FAILED = 3'd1;
    localparam logic [2:0] EV_PAYLOAD        = 3'd2;
    localparam logic [2:0] EV_EMPTY          = 3'd3;
    localparam logic [2:0] EV_CLOSED         = 3'd4;
    localparam logic [2:0] EV_BAD_HEADER     = 3'd5;

    // configuration register indexes
    localparam logic CFG_MAGIC_WORD  = 1'b0;
    localparam logic CFG_MAX_PAYLOAD = 1'b1;

    typedef enum logic [3:0] {
        ST_CONNECTING   = 4'b0001,
        ST_DISCONNECTED = 4'b0010,
        ST_HEADER       = 4'b0100,
        ST_PAYLOAD      = 4'b1000
    } t_link_state;

    typedef struct packed {
        logic [1:0] req_type;
        logic       connect_ok;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] payload_byte;
        logic       last;
    } t_result;

endpackage

// ===== src/lpfr_in_reg.sv =====
// Input register of the frame receiver: holds one accepted word until the
// parser takes it. Depends on lpfr_pkg.
module lpfr_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  lpfr_pkg::t_item i_item,
    input  logic            i_take,
    output logic            o_valid,
    output lpfr_pkg::t_item o_item
);

    logic            r_valid;
    lpfr_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    // a held word is never dropped without being taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_take |=> r_valid && $stable(r_item))
        else $error("input register lost a word");

endmodule

// ===== src/lpfr_parser.sv =====
// Link state machine and frame parser: gathers header bytes, checks size
// and magic word, counts payload bytes. Depends on lpfr_pkg.
module lpfr_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  lpfr_pkg::t_item                i_item,
    input  logic [lpfr_pkg::WORD_W-1:0]    i_magic_word,
    input  logic [lpfr_pkg::LEN_W-1:0]     i_max_payload,
    output logic                           o_has_result,
    output lpfr_pkg::t_result              o_result
);

    lpfr_pkg::t_link_state             r_state, n_state;
    logic [63:0]                       r_hdr, n_hdr;
    logic [lpfr_pkg::HCNT_W-1:0]       r_hcnt, n_hcnt;
    logic [lpfr_pkg::LEN_W-1:0]        r_left, n_left;

    logic [63:0]                       hdr_shift;
    logic [lpfr_pkg::WORD_W-1:0]       hdr_size;
    logic [lpfr_pkg::WORD_W-1:0]       hdr_magic;
    logic                              hdr_done;
    logic                              size_bad;

    // bytes arrive in order, so shift in from the top: byte 0 ends at [7:0]
    assign hdr_shift = {i_item.rx_byte, r_hdr[63:8]};
    assign hdr_size  = hdr_shift[31:0];
    assign hdr_magic = hdr_shift[63:32];
    assign hdr_done  = (r_hcnt == lpfr_pkg::HCNT_W'(lpfr_pkg::HEADER_BYTES - 1));
    assign size_bad  = hdr_size > {{(lpfr_pkg::WORD_W - lpfr_pkg::LEN_W){1'b0}}, i_max_payload};

    always_comb begin
        n_state      = r_state;
        n_hdr        = r_hdr;
        n_hcnt       = r_hcnt;
        n_left       = r_left;
        o_has_result = 1'b0;
        o_result     = '{event_res: lpfr_pkg::EV_CONNECTED, payload_byte: 8'd0, last: 1'b0};
        if (i_fire) begin
            unique case (i_item.req_type)
                lpfr_pkg::REQ_OPEN: begin
                    if (r_state == lpfr_pkg::ST_DISCONNECTED) begin
                        n_state = lpfr_pkg::ST_CONNECTING;
                    end
                end
                lpfr_pkg::REQ_CONNECT: begin
                    if (r_state == lpfr_pkg::ST_CONNECTING) begin
                        o_has_result = 1'b1;
                        if (i_item.connect_ok) begin
                            n_state = lpfr_pkg::ST_HEADER;
                            n_hdr   = '0;
                            n_hcnt  = '0;
                            n_left  = '0;
                        end else begin
                            n_state            = lpfr_pkg::ST_DISCONNECTED;
                            o_result.event_res = lpfr_pkg::EV_CONNECT_FAILED;
                        end
                    end
                end
                lpfr_pkg::REQ_BYTE: begin
                    if (r_state == lpfr_pkg::ST_HEADER) begin
                        n_hdr  = hdr_shift;
                        n_hcnt = r_hcnt + lpfr_pkg::HCNT_W'(1);
                        if (hdr_done) begin
                            n_hdr  = '0;
                            n_hcnt = '0;
                            if (size_bad || hdr_magic != i_magic_word) begin
                                n_state            = lpfr_pkg::ST_DISCONNECTED;
                                o_has_result       = 1'b1;
                                o_result.event_res = lpfr_pkg::EV_BAD_HEADER;
                            end else if (hdr_size == '0) begin
                                o_has_result       = 1'b1;
                                o_result.event_res = lpfr_pkg::EV_EMPTY;
                            end else begin
                                n_left  = hdr_size[lpfr_pkg::LEN_W-1:0];
                                n_state = lpfr_pkg::ST_PAYLOAD;
                            end
                        end
                    end else if (r_state == lpfr_pkg::ST_PAYLOAD) begin
                        n_left                = r_left - lpfr_pkg::LEN_W'(1);
                        o_has_result          = 1'b1;
                        o_result.event_res    = lpfr_pkg::EV_PAYLOAD;
                        o_result.payload_byte = i_item.rx_byte;
                        o_result.last         = (r_left == lpfr_pkg::LEN_W'(1));
                        if (r_left == lpfr_pkg::LEN_W'(1)) begin
                            n_state = lpfr_pkg::ST_HEADER;
                            n_hdr   = '0;
                            n_hcnt  = '0;
                        end
                    end
                end
                lpfr_pkg::REQ_CLOSE: begin
                    if (r_state != lpfr_pkg::ST_DISCONNECTED) begin
                        n_state            = lpfr_pkg::ST_DISCONNECTED;
                        o_has_result       = 1'b1;
                        o_result.event_res = lpfr_pkg::EV_CLOSED;
                    end
                end
                default: begin
                    n_state = r_state;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpfr_pkg::ST_DISCONNECTED;
            r_hdr   <= '0;
            r_hcnt  <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_hdr   <= n_hdr;
            r_hcnt  <= n_hcnt;
            r_left  <= n_left;
        end
    end

    // payload state always has bytes outstanding
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lpfr_pkg::ST_PAYLOAD |-> r_left != '0)
        else $error("payload state with no bytes left");

    // end of message returns to a fresh header
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_has_result && o_result.last |=> r_state == lpfr_pkg::ST_HEADER && r_hcnt == '0)
        else $error("last byte did not restart header gathering");

endmodule

// ===== src/lpfr_out_reg.sv =====
// Result register of the frame receiver: holds one result word until the
// consumer takes it. Depends on lpfr_pkg.
module lpfr_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  lpfr_pkg::t_result i_result,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output lpfr_pkg::t_result o_result
);

    logic              r_valid;
    lpfr_pkg::t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

    // a load only ever lands in a free register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result overwritten before it was taken");

endmodule

// ===== src/length_prefixed_frame_receiver_core.sv =====
// Top level of the length-prefixed frame receiver.
// Depends on lpfr_pkg, lpfr_in_reg, lpfr_parser and lpfr_out_reg.
//
// Follows one link through open, connect outcome, received byte and close
// words, and splits the byte stream into frames: an 8-byte header (a
// little-endian 32-bit payload size, then a little-endian 32-bit magic word)
// followed by the payload. Each payload byte leaves as a result word with
// last set on the final byte; a zero-size frame gives one empty-message word;
// a size above max_payload or a wrong magic word gives bad header and drops
// the link. One input word is taken every cycle when the result side keeps
// up; a word is held in the input register and, once the result register
// is free, passes the parser into the result register, which presents its
// result. Words that cause no result are simply consumed. The rate is set
// by the single parser stage, which updates link state, header shift
// register and byte counter once per cycle while words are taken.
// Configuration words are taken at once (ready is always high) and must only
// be sent while the block is idle.
module length_prefixed_frame_receiver_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic        i_connect_ok,
    input  logic [7:0]  i_rx_byte,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_payload_byte,
    output logic        o_last,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    lpfr_pkg::t_item                   in_item;
    lpfr_pkg::t_item                   held_item;
    lpfr_pkg::t_result                 pr_result;
    lpfr_pkg::t_result                 out_result;
    logic                              held_valid;
    logic                              out_free;
    logic                              fire;
    logic                              pr_has;
    logic [lpfr_pkg::WORD_W-1:0]       r_magic_word;
    logic [lpfr_pkg::LEN_W-1:0]        r_max_payload;

    assign in_item = '{req_type: i_req_type, connect_ok: i_connect_ok, rx_byte: i_rx_byte};

    // advance the held word whenever the result register can take its outcome
    assign fire = held_valid && out_free;

    // configuration registers: always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_word  <= lpfr_pkg::MAGIC_RESET;
            r_max_payload <= lpfr_pkg::MAX_PAYLOAD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lpfr_pkg::CFG_MAGIC_WORD:  r_magic_word  <= i_cfg_data;
                lpfr_pkg::CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[lpfr_pkg::LEN_W-1:0];
                default:                   r_magic_word  <= r_magic_word;
            endcase
        end
    end

    lpfr_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .i_take  (fire),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    lpfr_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_item        (held_item),
        .i_magic_word  (r_magic_word),
        .i_max_payload (r_max_payload),
        .o_has_result  (pr_has),
        .o_result      (pr_result)
    );

    lpfr_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (pr_has),
        .i_result (pr_result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_event_res    = out_result.event_res;
    assign o_payload_byte = out_result.payload_byte;
    assign o_last         = out_result.last;

    // a result word only ever comes from a word the parser took
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pr_has |-> fire)
        else $error("parser produced a result without taking a word");

endmodule

// ===== sim/length_prefixed_frame_receiver_core_tb.sv =====
// Self-checking testbench for length_prefixed_frame_receiver_core.
// Depends on lpfr_pkg and the core; runs link sessions and framed byte streams
// under several register settings and checks every result word in order.
module length_prefixed_frame_receiver_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // input ports, all known from time zero
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_req_type   = lpfr_pkg::REQ_OPEN;
    logic        i_connect_ok = 1'b0;
    logic [7:0]  i_rx_byte    = 8'd0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [2:0]  o_event_res;
    logic [7:0]  o_payload_byte;
    logic        o_last;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index  = lpfr_pkg::CFG_MAGIC_WORD;
    logic [31:0] i_cfg_data   = 32'd0;

    length_prefixed_frame_receiver_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_connect_ok   (i_connect_ok),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_res    (o_event_res),
        .o_payload_byte (o_payload_byte),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial forever #1 i_clk = ~i_clk;

    // Generous ceiling; a correct run finishes far inside it.
    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Link tracker: own copy of registers and link state, fed with every
    // accepted input word, producing the result words the core must give.
    // ------------------------------------------------------------------
    logic [31:0]                magic_reg    = lpfr_pkg::MAGIC_RESET;
    logic [lpfr_pkg::LEN_W-1:0] max_len      = lpfr_pkg::MAX_PAYLOAD_RESET;
    lpfr_pkg::t_link_state      link_st      = lpfr_pkg::ST_DISCONNECTED;
    logic [63:0]                hdr_shift    = 64'd0;
    logic [3:0]                 hdr_count    = 4'd0;
    logic [lpfr_pkg::LEN_W-1:0] payload_left = '0;

    lpfr_pkg::t_result due_results[$];
    lpfr_pkg::t_item   pending_words[$];

    int unsigned words_planned = 0;
    int unsigned words_taken   = 0;
    int unsigned results_seen  = 0;
    int unsigned mismatches    = 0;
    int unsigned ev_seen[6]    = '{default: 0};
    logic        all_due_in    = 1'b1;

    task automatic follow_link(input lpfr_pkg::t_item w);
        lpfr_pkg::t_result r;
        logic              has_result;
        logic [31:0]       size_f;
        logic [31:0]       magic_f;
        r          = '0;
        has_result = 1'b0;
        case (w.req_type)
            lpfr_pkg::REQ_OPEN: begin
                if (link_st == lpfr_pkg::ST_DISCONNECTED) link_st = lpfr_pkg::ST_CONNECTING;
            end
            lpfr_pkg::REQ_CONNECT: begin
                if (link_st == lpfr_pkg::ST_CONNECTING) begin
                    has_result = 1'b1;
                    if (w.connect_ok) begin
                        link_st      = lpfr_pkg::ST_HEADER;
                        hdr_shift    = 64'd0;
                        hdr_count    = 4'd0;
                        payload_left = '0;
                        r.event_res  = lpfr_pkg::EV_CONNECTED;
                    end else begin
                        link_st     = lpfr_pkg::ST_DISCONNECTED;
                        r.event_res = lpfr_pkg::EV_CONNECT_FAILED;
                    end
                end
            end
            lpfr_pkg::REQ_BYTE: begin
                if (link_st == lpfr_pkg::ST_HEADER) begin
                    // gather little-endian header bytes, judge it on the eighth
                    hdr_shift[8*hdr_count[2:0] +: 8] = w.rx_byte;
                    hdr_count = hdr_count + 4'd1;
                    if (hdr_count == 4'(lpfr_pkg::HEADER_BYTES)) begin
                        size_f    = hdr_shift[31:0];
                        magic_f   = hdr_shift[63:32];
                        hdr_shift = 64'd0;
                        hdr_count = 4'd0;
                        if (size_f > {6'd0, max_len} || magic_f != magic_reg) begin
                            link_st     = lpfr_pkg::ST_DISCONNECTED;
                            has_result  = 1'b1;
                            r.event_res = lpfr_pkg::EV_BAD_HEADER;
                        end else if (size_f == 32'd0) begin
                            has_result  = 1'b1;
                            r.event_res = lpfr_pkg::EV_EMPTY;
                        end else begin
                            payload_left = size_f[lpfr_pkg::LEN_W-1:0];
                            link_st      = lpfr_pkg::ST_PAYLOAD;
                        end
                    end
                end else if (link_st == lpfr_pkg::ST_PAYLOAD) begin
                    payload_left   = payload_left - 26'd1;
                    has_result     = 1'b1;
                    r.event_res    = lpfr_pkg::EV_PAYLOAD;
                    r.payload_byte = w.rx_byte;
                    r.last         = (payload_left == '0);
                    if (payload_left == '0) begin
                        link_st   = lpfr_pkg::ST_HEADER;
                        hdr_shift = 64'd0;
                        hdr_count = 4'd0;
                    end
                end
            end
            default: begin
                if (link_st != lpfr_pkg::ST_DISCONNECTED) begin
                    link_st     = lpfr_pkg::ST_DISCONNECTED;
                    has_result  = 1'b1;
                    r.event_res = lpfr_pkg::EV_CLOSED;
                end
            end
        endcase
        if (has_result) due_results.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Word source: bursts of random length, random gaps, and now and then
    // a hold until every outstanding result has come back.
    // ------------------------------------------------------------------
    int unsigned words_sent  = 0;
    int          burst_left  = 1;
    int          gap_left    = 0;
    logic        drain_wait  = 1'b0;
    logic        drained_yet = 1'b0;

    always @(posedge i_clk) begin
        lpfr_pkg::t_item w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_ready) begin
            // hold the word until it is taken
        end else if (gap_left != 0) begin
            gap_left   = gap_left - 1;
            i_in_valid <= 1'b0;
        end else if (drain_wait) begin
            if (all_due_in) drain_wait = 1'b0;
            i_in_valid <= 1'b0;
        end else if (pending_words.size() == 0) begin
            i_in_valid <= 1'b0;
        end else begin
            w = pending_words.pop_front();
            i_req_type   <= w.req_type;
            i_connect_ok <= w.connect_ok;
            i_rx_byte    <= w.rx_byte;
            i_in_valid   <= 1'b1;
            words_sent   = words_sent + 1;
            burst_left   = burst_left - 1;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                // pause once for certain, then at random
                if ((!drained_yet && words_sent > 150) || $urandom_range(0, 39) == 0) begin
                    drain_wait  = 1'b1;
                    drained_yet = 1'b1;
                end
            end
        end
    end

    // Evaluate the drain condition away from the active edge.
    always @(negedge i_clk) begin
        all_due_in = (due_results.size() == 0) && !i_in_valid;
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted input word, then compare each
    // accepted result word with the oldest one due. Stall the result side
    // on a rotating pattern that is redrawn each time the 7-bit phase wraps.
    // ------------------------------------------------------------------
    logic [31:0] stall_pat   = 32'hFFFF_FFFF;
    logic [6:0]  stall_phase = 7'd0;

    always @(posedge i_clk) begin
        lpfr_pkg::t_item   w;
        lpfr_pkg::t_result got;
        lpfr_pkg::t_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                w.req_type   = i_req_type;
                w.connect_ok = i_connect_ok;
                w.rx_byte    = i_rx_byte;
                words_taken  = words_taken + 1;
                follow_link(w);
            end
            if (o_out_valid && i_out_ready) begin
                got.event_res    = o_event_res;
                got.payload_byte = o_payload_byte;
                got.last         = o_last;
                results_seen     = results_seen + 1;
                if (got.event_res <= lpfr_pkg::EV_BAD_HEADER) begin
                    ev_seen[got.event_res] = ev_seen[got.event_res] + 1;
                end
                if (due_results.size() == 0) begin
                    $error("result word with nothing due: event_res %0d", got.event_res);
                    mismatches = mismatches + 1;
                end else begin
                    want = due_results.pop_front();
                    if (got.event_res !== want.event_res) begin
                        $error("event_res: expected %0d, got %0d",
                               want.event_res, got.event_res);
                        mismatches = mismatches + 1;
                    end
                    if (got.payload_byte !== want.payload_byte) begin
                        $error("payload_byte: expected %0h, got %0h",
                               want.payload_byte, got.payload_byte);
                        mismatches = mismatches + 1;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, got.last);
                        mismatches = mismatches + 1;
                    end
                end
            end
            stall_phase = stall_phase + 7'd1;
            if (stall_phase == 7'd0) begin
                case ($urandom_range(0, 3))
                    0: stall_pat = 32'hFFFF_FFFF;
                    1: stall_pat = $urandom;
                    2: stall_pat = $urandom | $urandom;
                    default: stall_pat = $urandom & $urandom;
                endcase
            end
            stall_pat = {stall_pat[0], stall_pat[31:1]};
            i_out_ready <= stall_pat[0];
        end
    end

    // ------------------------------------------------------------------
    // Stimulus building blocks
    // ------------------------------------------------------------------
    task automatic queue_word(input logic [1:0] req, input logic ok, input logic [7:0] b,
                              input bit counted);
        lpfr_pkg::t_item w;
        w.req_type   = req;
        w.connect_ok = ok;
        w.rx_byte    = b;
        pending_words.push_back(w);
        if (counted) words_planned = words_planned + 1;
    endtask

    // Queue the first 'upto' bytes of a header, size then magic, low byte first.
    task automatic queue_header(input logic [31:0] size_f, input logic [31:0] magic_f,
                                input int upto);
        logic [63:0] hdr;
        hdr = {magic_f, size_f};
        for (int i = 0; i < upto; i++) begin
            queue_word(lpfr_pkg::REQ_BYTE, 1'($urandom), hdr[8*i +: 8], 1);
        end
    endtask

    // Payload bytes, with the odd open or connect word slipped in (both ignored).
    task automatic queue_payload(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 32) == 0) begin
                queue_word($urandom_range(0, 1) ? lpfr_pkg::REQ_OPEN : lpfr_pkg::REQ_CONNECT,
                           1'($urandom), 8'($urandom), 0);
            end
            queue_word(lpfr_pkg::REQ_BYTE, 1'($urandom), 8'($urandom), 1);
        end
    endtask

    function automatic int size_cap();
        return (max_len > 26'd300) ? 300 : int'(max_len);
    endfunction

    // Mostly short frames, some up to the cap, some exactly on it.
    function automatic int pick_size();
        int cap;
        int r;
        cap = size_cap();
        r   = $urandom_range(0, 9);
        if (cap == 0) return 0;
        if (r == 0) return cap;
        if (r < 7) return $urandom_range(1, (cap < 12) ? cap : 12);
        return $urandom_range(1, cap);
    endfunction

    // Sizes that must be refused: just over the limit, or with upper bits set.
    function automatic logic [31:0] pick_oversize();
        case ($urandom_range(0, 2))
            0: return {6'd0, max_len} + 32'd1;
            1: return $urandom | 32'h8000_0000;
            default: return {6'($urandom_range(1, 63)), 26'($urandom_range(0, 15))};
        endcase
    endfunction

    // One session: clear any leftover link, open, connect (now and then refused), then a run of frames.
    task automatic queue_session();
        int          frames;
        int          kind;
        int          sz;
        logic [31:0] bad_magic;
        bit          alive;
        queue_word(lpfr_pkg::REQ_CLOSE, 1'($urandom), 8'($urandom), 0);
        queue_word(lpfr_pkg::REQ_OPEN, 1'($urandom), 8'($urandom), 1);
        if ($urandom_range(0, 9) == 0) begin
            queue_word(lpfr_pkg::REQ_CONNECT, 1'b0, 8'($urandom), 1);
            return;
        end
        queue_word(lpfr_pkg::REQ_CONNECT, 1'b1, 8'($urandom), 1);
        frames = $urandom_range(1, 8);
        alive  = 1'b1;
        for (int f = 0; f < frames && alive; f++) begin
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                queue_header(32'd0, magic_reg, 8);
            end else if (kind < 16) begin
                bad_magic = magic_reg ^ ($urandom | (32'd1 << $urandom_range(0, 31)));
                queue_header(32'(pick_size()), bad_magic, 8);
                alive = 1'b0;
            end else if (kind < 23) begin
                queue_header(pick_oversize(), magic_reg, 8);
                alive = 1'b0;
            end else if (kind < 30) begin
                // drop the link part way through a frame
                if (size_cap() >= 2 && $urandom_range(0, 1) == 1) begin
                    sz = $urandom_range(2, size_cap());
                    queue_header(32'(sz), magic_reg, 8);
                    queue_payload($urandom_range(1, sz - 1));
                end else begin
                    queue_header(32'(pick_size()), magic_reg, $urandom_range(1, 7));
                end
                queue_word(lpfr_pkg::REQ_CLOSE, 1'($urandom), 8'($urandom), 1);
                alive = 1'b0;
            end else begin
                sz = pick_size();
                queue_header(32'(sz), magic_reg, 8);
                queue_payload(sz);
            end
        end
        if (alive && $urandom_range(0, 1) == 1) begin
            queue_word(lpfr_pkg::REQ_CLOSE, 1'($urandom), 8'($urandom), 1);
        end
    endtask

    // Short stretch of arbitrary words.
    task automatic queue_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            queue_word(2'($urandom), 1'($urandom), 8'($urandom), 0);
        end
    endtask

    task automatic queue_traffic(input int unsigned quota);
        int unsigned start;
        start = words_planned;
        while (words_planned - start < quota) begin
            if ($urandom_range(0, 9) == 0) queue_noise();
            else queue_session();
        end
    endtask

    // Wait for the core to go idle: nothing queued, nothing in flight, then
    // let the pipeline finish any word that gave no result.
    task automatic settle();
        while (pending_words.size() != 0 || i_in_valid || due_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == lpfr_pkg::CFG_MAGIC_WORD) magic_reg = data;
        else max_len = data[lpfr_pkg::LEN_W-1:0];
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    localparam int unsigned PHASES = 6;
    localparam int unsigned QUOTA  = 1450 / PHASES;

    initial begin
        // directed opening under reset settings
        queue_word(lpfr_pkg::REQ_CLOSE,   1'b1, 8'($urandom), 1);  // close while down
        queue_word(lpfr_pkg::REQ_CONNECT, 1'b1, 8'($urandom), 1);  // outcome while down
        queue_word(lpfr_pkg::REQ_BYTE,    1'b0, 8'hFF, 1);         // byte while down
        queue_word(lpfr_pkg::REQ_OPEN,    1'b0, 8'($urandom), 1);  // go to connecting
        queue_word(lpfr_pkg::REQ_OPEN,    1'b1, 8'($urandom), 1);  // open while connecting
        queue_word(lpfr_pkg::REQ_BYTE,    1'b1, 8'h00, 1);         // byte while connecting
        queue_word(lpfr_pkg::REQ_CONNECT, 1'b0, 8'($urandom), 1);  // connect failed
        queue_word(lpfr_pkg::REQ_OPEN,    1'b0, 8'($urandom), 1);
        queue_word(lpfr_pkg::REQ_CLOSE,   1'b0, 8'($urandom), 1);  // close while connecting
        queue_word(lpfr_pkg::REQ_OPEN,    1'b1, 8'($urandom), 1);
        queue_word(lpfr_pkg::REQ_CONNECT, 1'b1, 8'($urandom), 1);  // connected
        queue_word(lpfr_pkg::REQ_CONNECT, 1'b0, 8'($urandom), 1);  // outcome in header
        queue_header(32'd0, lpfr_pkg::MAGIC_RESET, 8);             // empty message
        queue_word(lpfr_pkg::REQ_CLOSE,   1'b1, 8'($urandom), 1);  // close in header

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        queue_traffic(QUOTA);
        settle();

        for (int p = 1; p < PHASES; p++) begin
            case (p)
                1: begin
                    write_reg(lpfr_pkg::CFG_MAGIC_WORD, $urandom);
                    write_reg(lpfr_pkg::CFG_MAX_PAYLOAD, 32'd64);
                end
                2: begin
                    write_reg(lpfr_pkg::CFG_MAGIC_WORD, 32'h0000_0000);
                    write_reg(lpfr_pkg::CFG_MAX_PAYLOAD, 32'd0);
                end
                3: begin
                    write_reg(lpfr_pkg::CFG_MAGIC_WORD, 32'hFFFF_FFFF);
                    write_reg(lpfr_pkg::CFG_MAX_PAYLOAD, 32'd33554432);
                end
                4: begin
                    write_reg(lpfr_pkg::CFG_MAX_PAYLOAD, $urandom_range(1, 300));
                    write_reg(lpfr_pkg::CFG_MAGIC_WORD, $urandom);
                end
                default: begin
                    write_reg(lpfr_pkg::CFG_MAGIC_WORD, lpfr_pkg::MAGIC_RESET);
                    write_reg(lpfr_pkg::CFG_MAX_PAYLOAD, $urandom_range(301, 33554432));
                end
            endcase
            @(negedge i_clk);
            queue_traffic(QUOTA);
            settle();
        end

        $display("covered %0d input words over %0d register settings, %0d results checked",
                 words_taken, PHASES, results_seen);
        $display("connected %0d, connect failed %0d, payload bytes %0d, empty %0d",
                 ev_seen[lpfr_pkg::EV_CONNECTED], ev_seen[lpfr_pkg::EV_CONNECT_FAILED],
                 ev_seen[lpfr_pkg::EV_PAYLOAD], ev_seen[lpfr_pkg::EV_EMPTY]);
        $display("closed %0d, bad header %0d",
                 ev_seen[lpfr_pkg::EV_CLOSED], ev_seen[lpfr_pkg::EV_BAD_HEADER]);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
